FILE: design/rbed_pkg.sv
package rbed_pkg;

   localparam int COORD_W   = 16;
   localparam int FRAC_BITS = 12;
   localparam int DIFF_W    = COORD_W + 1;
   // dividend = diff << FRAC_BITS
   localparam int NUM_W     = DIFF_W + FRAC_BITS;
   // quotient magnitude never exceeds dividend magnitude
   localparam int QUO_W     = NUM_W + 1;
   // magnitude widths for the restoring divider
   localparam int NMAG_W    = NUM_W;
   localparam int DMAG_W    = COORD_W;
   localparam int EXIT_W    = 24;
   localparam int DIV_STEPS = NMAG_W;

   localparam logic signed [COORD_W-1:0] BOX_LOW_RST  = -16'sd4096;
   localparam logic signed [COORD_W-1:0] BOX_HIGH_RST = 16'sd4096;

   typedef enum logic [2:0] {
      REG_X_LOW  = 3'd0,
      REG_X_HIGH = 3'd1,
      REG_Y_LOW  = 3'd2,
      REG_Y_HIGH = 3'd3,
      REG_Z_LOW  = 3'd4,
      REG_Z_HIGH = 3'd5
   } reg_idx_type;

   // slab bounds flags travelling with one axis
   typedef struct packed {
      logic in_slab;  // origin inside the slab
      logic zero_dir; // direction component is zero
   } slab_flags_type;

endpackage

FILE: design/rbed_div.sv
module rbed_div
   import rbed_pkg::*;
(
   input  logic                      clock,
   input  logic signed [NUM_W-1:0]   in_num,
   input  logic signed [COORD_W-1:0] in_den,
   output logic signed [QUO_W-1:0]   out_quo
);
   // Pipelined restoring divider, a load stage then one quotient bit per stage,
   // truncating toward zero. Zero divisor gives garbage that the caller masks.
   logic [NMAG_W-1:0] num_ff [DIV_STEPS+1];
   logic [DMAG_W-1:0] den_ff [DIV_STEPS+1];
   logic [DMAG_W:0]   rem_ff [DIV_STEPS+1];
   logic              neg_ff [DIV_STEPS+1];

   logic [NMAG_W-1:0] num_in;
   logic [DMAG_W-1:0] den_in;

   // take magnitudes
   always_comb begin
      num_in = in_num[NUM_W-1] ? NMAG_W'(-in_num) : NMAG_W'(in_num);
      den_in = in_den[COORD_W-1] ? DMAG_W'(-in_den) : DMAG_W'(in_den);
   end

   always_ff @(posedge clock) begin
      num_ff[0] <= num_in;
      den_ff[0] <= den_in;
      rem_ff[0] <= '0;
      neg_ff[0] <= in_num[NUM_W-1] ^ in_den[COORD_W-1];
   end

   // one quotient bit per stage, shifted into num from the bottom
   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
      logic [DMAG_W+1:0] trial;
      logic [DMAG_W:0]   shifted;
      always_comb begin
         shifted = {rem_ff[s][DMAG_W-1:0], num_ff[s][NMAG_W-1]};
         trial   = {1'b0, shifted} - {2'b00, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         rem_ff[s+1] <= trial[DMAG_W+1] ? shifted : trial[DMAG_W:0];
         num_ff[s+1] <= {num_ff[s][NMAG_W-2:0], ~trial[DMAG_W+1]};
         den_ff[s+1] <= den_ff[s];
         neg_ff[s+1] <= neg_ff[s];
      end
   end

   // apply sign
   always_comb begin
      out_quo = neg_ff[DIV_STEPS] ? -$signed({1'b0, num_ff[DIV_STEPS]})
                                  :  $signed({1'b0, num_ff[DIV_STEPS]});
   end

endmodule

FILE: design/ray_box_exit_distance.sv
// Ray / axis-aligned box slab test with exit distance.
// Input: pulse req_start with the ray on req_origin_* / req_dir_*; it is
// taken when req_busy is low. req_busy is tied low: a ray may enter every
// cycle.
// Result: rsp_valid strobes for one cycle with rsp_hit and
// rsp_exit_distance (Q11.12, saturated). On a miss the distance is zero.
// Pipeline: two setup stages, a 30-stage divider (one load stage and one
// quotient bit in each of 29 stages), then three combine stages.
// Throughput one ray per cycle, set by the six parallel pipelined dividers.
// Box bounds are written through csr_valid/csr_ready/csr_index/csr_data;
// the user must write them only while no ray is in flight, the block does
// not enforce this. csr_ready is always high, indexes above five are ignored.
// Reset: synchronous, clears all valid bits in the pipeline and loads
// the bounds to a unit box of -1.0 .. +1.0.
// The receiver cannot stall; results are never held.
module ray_box_exit_distance
   import rbed_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_start,
   output logic                      req_busy,
   input  logic signed [COORD_W-1:0] req_origin_x,
   input  logic signed [COORD_W-1:0] req_origin_y,
   input  logic signed [COORD_W-1:0] req_origin_z,
   input  logic signed [COORD_W-1:0] req_dir_x,
   input  logic signed [COORD_W-1:0] req_dir_y,
   input  logic signed [COORD_W-1:0] req_dir_z,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [COORD_W-1:0]        csr_data,
   output logic                      rsp_valid,
   output logic                      rsp_hit,
   output logic signed [EXIT_W-1:0]  rsp_exit_distance
);
   localparam int DLAT = DIV_STEPS + 1;
   localparam int CW   = QUO_W + 1; // compare width, room for infinities
   localparam logic signed [CW-1:0] T_POS = {2'b01, {(CW-2){1'b0}}};
   localparam logic signed [CW-1:0] T_NEG = {2'b10, {(CW-2){1'b0}}};
   localparam logic signed [CW-1:0] E_MAX = CW'(24'sh7FFFFF);
   localparam logic signed [CW-1:0] E_MIN = -CW'(25'sh800000);

   logic signed [COORD_W-1:0] bnd_ff [6];

   assign req_busy  = 1'b0;
   assign csr_ready = 1'b1;

   // hold box bounds
   always_ff @(posedge clock) begin
      if (reset) begin
         bnd_ff[REG_X_LOW]  <= BOX_LOW_RST;
         bnd_ff[REG_X_HIGH] <= BOX_HIGH_RST;
         bnd_ff[REG_Y_LOW]  <= BOX_LOW_RST;
         bnd_ff[REG_Y_HIGH] <= BOX_HIGH_RST;
         bnd_ff[REG_Z_LOW]  <= BOX_LOW_RST;
         bnd_ff[REG_Z_HIGH] <= BOX_HIGH_RST;
      end else if (csr_valid && csr_index <= 3'(REG_Z_HIGH)) begin
         bnd_ff[csr_index] <= $signed(csr_data);
      end
   end

   // stage 1: register ray
   logic                      v1_ff;
   logic signed [COORD_W-1:0] o1_ff [3];
   logic signed [COORD_W-1:0] d1_ff [3];
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= req_start;
      o1_ff[0] <= req_origin_x; o1_ff[1] <= req_origin_y; o1_ff[2] <= req_origin_z;
      d1_ff[0] <= req_dir_x;    d1_ff[1] <= req_dir_y;    d1_ff[2] <= req_dir_z;
   end

   // stage 2: differences, bound swap, slab flags
   logic                      v2_ff;
   logic signed [NUM_W-1:0]   nmin_ff [3];
   logic signed [NUM_W-1:0]   nmax_ff [3];
   logic signed [COORD_W-1:0] d2_ff   [3];
   slab_flags_type            f2_ff   [3];
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
   end
   for (genvar a = 0; a < 3; a++) begin : g_ax
      logic signed [DIFF_W-1:0] dl, dh;
      logic                     pos;
      always_comb begin
         dl  = DIFF_W'(bnd_ff[2*a]) - DIFF_W'(o1_ff[a]);
         dh  = DIFF_W'(bnd_ff[2*a+1]) - DIFF_W'(o1_ff[a]);
         pos = !d1_ff[a][COORD_W-1];
      end
      always_ff @(posedge clock) begin
         nmin_ff[a] <= pos ? {dl, FRAC_BITS'(0)} : {dh, FRAC_BITS'(0)};
         nmax_ff[a] <= pos ? {dh, FRAC_BITS'(0)} : {dl, FRAC_BITS'(0)};
         d2_ff[a]   <= d1_ff[a];
         f2_ff[a].zero_dir <= (d1_ff[a] == '0);
         f2_ff[a].in_slab  <= (o1_ff[a] >= bnd_ff[2*a]) && (o1_ff[a] <= bnd_ff[2*a+1]);
      end
   end

   // dividers: six in parallel
   logic signed [QUO_W-1:0] qmin [3];
   logic signed [QUO_W-1:0] qmax [3];
   for (genvar a = 0; a < 3; a++) begin : g_dv
      rbed_div u_min (.clock, .in_num(nmin_ff[a]), .in_den(d2_ff[a]), .out_quo(qmin[a]));
      rbed_div u_max (.clock, .in_num(nmax_ff[a]), .in_den(d2_ff[a]), .out_quo(qmax[a]));
   end

   // delay valid and flags alongside the dividers
   logic [DLAT-1:0] vd_ff;
   slab_flags_type  fd_ff [DLAT][3];
   always_ff @(posedge clock) begin
      if (reset) vd_ff <= '0;
      else       vd_ff <= {vd_ff[DLAT-2:0], v2_ff};
      fd_ff[0] <= f2_ff;
      for (int i = 1; i < DLAT; i++) fd_ff[i] <= fd_ff[i-1];
   end

   // stage A: apply infinities, per-axis miss
   logic                v3_ff;
   logic signed [CW-1:0] tmin_ff [3];
   logic signed [CW-1:0] tmax_ff [3];
   logic [2:0]          okx_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= vd_ff[DLAT-1];
      for (int a = 0; a < 3; a++) begin
         if (fd_ff[DLAT-1][a].zero_dir) begin
            tmin_ff[a] <= T_NEG;
            tmax_ff[a] <= T_POS;
            okx_ff[a]  <= fd_ff[DLAT-1][a].in_slab;
         end else begin
            tmin_ff[a] <= CW'(qmin[a]);
            tmax_ff[a] <= CW'(qmax[a]);
            okx_ff[a]  <= 1'b1;
         end
      end
   end

   // stage B: combine x and y
   logic                v4_ff, ok4_ff;
   logic signed [CW-1:0] lo4_ff, hi4_ff, zmin4_ff, zmax4_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
      ok4_ff   <= okx_ff[0] && okx_ff[1] && okx_ff[2] &&
                  !(tmin_ff[0] > tmax_ff[1]) && !(tmin_ff[1] > tmax_ff[0]);
      lo4_ff   <= (tmin_ff[1] > tmin_ff[0]) ? tmin_ff[1] : tmin_ff[0];
      hi4_ff   <= (tmax_ff[1] < tmax_ff[0]) ? tmax_ff[1] : tmax_ff[0];
      zmin4_ff <= tmin_ff[2];
      zmax4_ff <= tmax_ff[2];
   end

   // stage C: z check, clamp, drive result
   logic signed [CW-1:0] hi_c;
   logic                 hit_c;
   logic                 v5_ff, hit5_ff;
   logic signed [EXIT_W-1:0] dist5_ff;
   always_comb begin
      hit_c = ok4_ff && !(lo4_ff > zmax4_ff) && !(zmin4_ff > hi4_ff);
      hi_c  = (zmax4_ff < hi4_ff) ? zmax4_ff : hi4_ff;
      if (hi_c > E_MAX)      hi_c = E_MAX;
      else if (hi_c < E_MIN) hi_c = E_MIN;
   end
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else       v5_ff <= v4_ff;
      hit5_ff  <= hit_c;
      dist5_ff <= hit_c ? EXIT_W'(hi_c) : '0;
   end

   assign rsp_valid         = v5_ff;
   assign rsp_hit           = hit5_ff;
   assign rsp_exit_distance = dist5_ff;

   // a result follows every accepted ray through the pipeline
   a_latency: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> ##(DLAT + 4) rsp_valid)
      else $error("result lost in pipeline");
   // a miss never carries a distance
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> rsp_exit_distance == '0)
      else $error("miss with nonzero distance");
   // no result without an earlier ray
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(v1_ff, DLAT + 4))
      else $error("result without a ray");
   a_stage_order: assert property (@(posedge clock) disable iff (reset)
      v4_ff |=> rsp_valid)
      else $error("stage valid dropped");

endmodule
